// ----- design/fixed_block_pool_allocator_defines.svh -----
// assertion macros shared by the allocator modules
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// concurrent assertion on an explicit clock and active-low reset
`define FBPA_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// concurrent assertion on clk_i and rst_ni of the enclosing module
`define FBPA_ASSERT(label, prop, msg) `FBPA_ASSERT_AT(label, clk_i, rst_ni, prop, msg)
`else
`define FBPA_ASSERT_AT(label, clk, rst_n, prop, msg)
`define FBPA_ASSERT(label, prop, msg)
`endif

`endif

// ----- design/fbpa_pkg.sv -----
// types and constants of the fixed block pool allocator
package fbpa_pkg;

  // field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned OFFSET_W = 26;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned ESIZE_W  = 16;
  localparam int unsigned EFF_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // smallest element size and buffer size
  localparam int unsigned MIN_ELEMENT = 8;
  localparam int unsigned MIN_BUFFER  = 16;

  // mode codes of an input item
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_BUFFER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_MODE = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RESET,
    OP_NONE
  } op_e;

  // input item
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] free_index;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                ok;
    logic [INDEX_W-1:0]  block_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  capacity;
  } out_item_t;

  // queued command from front to back
  typedef struct packed {
    op_e                op;
    logic [INDEX_W-1:0] free_index;
  } cmd_t;

  // live configuration seen by the back end
  typedef struct packed {
    logic [EFF_W-1:0]   eff_size;
    logic [COUNT_W-1:0] blocks_per_buffer;
    logic               static_mode;
  } cfg_t;

endpackage

// ----- design/fbpa_ram.sv -----
// generic single write port ram with registered read
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fbpa_size.sv -----
// rounds the element size up to the alignment by reciprocal multiplication
module fbpa_size #(
  parameter int unsigned ALIGNMENT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [fbpa_pkg::ESIZE_W-1:0] size_i,
  output logic                        busy_o,
  output logic [fbpa_pkg::EFF_W-1:0]  eff_o
);

  // raised size plus alignment minus one always fits in TW bits
  localparam int unsigned TW    = fbpa_pkg::EFF_W;
  localparam int unsigned LW    = $clog2(ALIGNMENT);
  localparam int unsigned SH    = TW + LW;
  localparam int unsigned RW    = TW + 2;
  localparam int unsigned PW    = TW + RW;
  localparam int unsigned QW    = RW - LW;
  localparam int unsigned XW    = QW + 7;
  localparam int unsigned RECIP = ((32'd1 << SH) + ALIGNMENT - 1) / ALIGNMENT;
  localparam int unsigned EFF_RESET =
    ((fbpa_pkg::MIN_ELEMENT + ALIGNMENT - 1) / ALIGNMENT) * ALIGNMENT;

  logic [1:0]                   stage_q, stage_d;
  logic [TW-1:0]                sum_q, sum_d;
  logic [QW-1:0]                quot_q, quot_d;
  logic [fbpa_pkg::EFF_W-1:0]   eff_q, eff_d;
  logic [fbpa_pkg::ESIZE_W-1:0] s_min;
  logic [PW-1:0]                recip_prod;
  logic [XW-1:0]                scaled;

  // raise to the minimum, divide by reciprocal, then scale back up
  always_comb begin
    s_min      = (size_i < fbpa_pkg::ESIZE_W'(fbpa_pkg::MIN_ELEMENT)) ?
                 fbpa_pkg::ESIZE_W'(fbpa_pkg::MIN_ELEMENT) : size_i;
    recip_prod = PW'(sum_q) * PW'(RECIP);
    scaled     = XW'(quot_q) * XW'(ALIGNMENT);
    stage_d    = {stage_q[0], load_i};
    sum_d      = load_i ? (TW'(s_min) + TW'(ALIGNMENT - 1)) : sum_q;
    quot_d     = stage_q[0] ? recip_prod[PW-1:SH] : quot_q;
    eff_d      = stage_q[1] ? scaled[fbpa_pkg::EFF_W-1:0] : eff_q;
  end

  // size unit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      sum_q   <= '0;
      quot_q  <= '0;
      eff_q   <= fbpa_pkg::EFF_W'(EFF_RESET);
    end else begin
      stage_q <= stage_d;
      sum_q   <= sum_d;
      quot_q  <= quot_d;
      eff_q   <= eff_d;
    end
  end

  assign busy_o = |stage_q;
  assign eff_o  = eff_q;

endmodule

// ----- design/fbpa_front.sv -----
// accepts items, classifies the mode and queues commands for the back end
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  fbpa_pkg::in_item_t  item_i,
  input  logic                hold_i,
  output logic                busy_o,
  output logic                cmd_valid_o,
  output fbpa_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);

  fbpa_pkg::cmd_t q_mem_q [2];
  logic [1:0]     count_q, count_d;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic           push;
  fbpa_pkg::cmd_t cmd_in;

  // mode classification
  always_comb begin
    cmd_in.free_index = item_i.free_index;
    case (item_i.mode)
      fbpa_pkg::MODE_ALLOC: cmd_in.op = fbpa_pkg::OP_ALLOC;
      fbpa_pkg::MODE_FREE:  cmd_in.op = fbpa_pkg::OP_FREE;
      fbpa_pkg::MODE_RESET: cmd_in.op = fbpa_pkg::OP_RESET;
      default:              cmd_in.op = fbpa_pkg::OP_NONE;
    endcase
  end

  // two-entry command queue control
  assign busy_o = (count_q == 2'd2) || hold_i;
  assign push   = start_i && !busy_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  `FBPA_ASSERT(a_no_overflow, push |-> (count_q != 2'd2), "item pushed into a full queue")
  `FBPA_ASSERT(a_pop_nonempty, cmd_pop_i |-> (count_q != 2'd0), "pop from an empty queue")
  `FBPA_ASSERT(a_count_bound, count_q != 2'd3, "queue count out of range")

endmodule

// ----- design/fbpa_back.sv -----
// executes queued commands on the free list and the capacity counters
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_back #(
  parameter int unsigned POOL_BLOCKS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  fbpa_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  fbpa_pkg::cfg_t      cfg_i,
  output logic                done_o,
  output fbpa_pkg::out_item_t result_o
);

  localparam int unsigned CW = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned IW = $clog2(POOL_BLOCKS);
  localparam int unsigned XW = (CW > fbpa_pkg::COUNT_W) ? CW : fbpa_pkg::COUNT_W;
  localparam int unsigned SW = XW + 1;
  localparam int unsigned MW = IW + fbpa_pkg::EFF_W;
  localparam int unsigned PW = (MW > fbpa_pkg::OFFSET_W) ? MW : fbpa_pkg::OFFSET_W;

  typedef enum logic {
    ST_IDLE,
    ST_LINK
  } state_e;

  state_e              state_q, state_d;
  logic [IW-1:0]       head_q, head_d;
  logic                ne_q, ne_d;
  logic [CW-1:0]       fresh_q, fresh_d;
  logic [CW-1:0]       free_q, free_d;
  logic [CW-1:0]       total_q, total_d;
  logic                done_q, done_d;
  fbpa_pkg::out_item_t result_q, result_d;

  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_rdata;
  logic [IW-1:0]       ram_wdata;
  logic [XW-1:0]       fx;
  logic [IW-1:0]       fidx;
  logic [XW-1:0]       bb;
  logic [XW-1:0]       rb;
  logic                grow;
  logic [SW-1:0]       tsum;
  logic [CW-1:0]       nt;
  logic [SW-1:0]       fsum;
  logic [CW-1:0]       free_g;
  logic [CW-1:0]       tot_n;
  logic [CW-1:0]       free_n;
  logic                res_ok;
  logic [IW-1:0]       res_idx;
  logic [MW-1:0]       prod;
  logic [PW-1:0]       prod_x;
  logic [XW-1:0]       idx_x;
  logic [XW-1:0]       free_x;
  logic [XW-1:0]       total_x;

  // link store of the free list
  fbpa_ram #(
    .WIDTH(IW),
    .DEPTH(POOL_BLOCKS)
  ) u_link (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fidx),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // buffer size, reset capacity and growth step
  always_comb begin
    fx     = XW'(cmd_i.free_index);
    fidx   = fx[IW-1:0];
    bb     = (cfg_i.blocks_per_buffer < fbpa_pkg::COUNT_W'(fbpa_pkg::MIN_BUFFER)) ?
             XW'(fbpa_pkg::MIN_BUFFER) : XW'(cfg_i.blocks_per_buffer);
    rb     = (bb > XW'(POOL_BLOCKS)) ? XW'(POOL_BLOCKS) : bb;
    grow   = (fresh_q >= total_q) && !cfg_i.static_mode && (total_q < CW'(POOL_BLOCKS));
    tsum   = SW'(total_q) + SW'(bb);
    nt     = (tsum > SW'(POOL_BLOCKS)) ? CW'(POOL_BLOCKS) : tsum[CW-1:0];
    fsum   = SW'(free_q) + SW'(nt) - SW'(total_q);
    free_g = (fsum > SW'(POOL_BLOCKS)) ? CW'(POOL_BLOCKS) : fsum[CW-1:0];
    tot_n  = grow ? nt : total_q;
    free_n = grow ? free_g : free_q;
    ram_wdata = ne_q ? head_q : fidx;
  end

  // command execution
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    ne_d      = ne_q;
    fresh_d   = fresh_q;
    free_d    = free_q;
    total_d   = total_q;
    done_d    = 1'b0;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    res_ok    = 1'b0;
    res_idx   = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          done_d    = 1'b1;
          case (cmd_i.op)
            fbpa_pkg::OP_ALLOC: begin
              if (ne_q) begin
                // pop waits in ST_LINK for the registered link read
                ram_re  = 1'b1;
                done_d  = 1'b0;
                state_d = ST_LINK;
              end else if (fresh_q < tot_n) begin
                res_ok  = 1'b1;
                res_idx = fresh_q[IW-1:0];
                fresh_d = fresh_q + 1'b1;
                total_d = tot_n;
                free_d  = (free_n != '0) ? (free_n - 1'b1) : free_n;
              end
            end
            fbpa_pkg::OP_FREE: begin
              if (fx < XW'(total_q)) begin
                ram_we = 1'b1;
                head_d = fidx;
                ne_d   = 1'b1;
                free_d = (free_q < CW'(POOL_BLOCKS)) ? (free_q + 1'b1) : free_q;
                res_ok = 1'b1;
              end
            end
            fbpa_pkg::OP_RESET: begin
              total_d = rb[CW-1:0];
              free_d  = rb[CW-1:0];
              fresh_d = '0;
              head_d  = '0;
              ne_d    = 1'b0;
              res_ok  = 1'b1;
            end
            default: begin
              res_ok = 1'b0;
            end
          endcase
        end
      end
      ST_LINK: begin
        // a self-linked block ends the list
        res_ok  = 1'b1;
        res_idx = head_q;
        done_d  = 1'b1;
        if (ram_rdata == head_q) begin
          ne_d = 1'b0;
        end else begin
          head_d = ram_rdata;
        end
        free_d  = (free_q != '0) ? (free_q - 1'b1) : free_q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result fields
  assign prod = res_idx * cfg_i.eff_size;

  always_comb begin
    prod_x  = PW'(prod);
    idx_x   = XW'(res_idx);
    free_x  = XW'(free_d);
    total_x = XW'(total_d);
    result_d.ok          = res_ok;
    result_d.block_index = idx_x[fbpa_pkg::INDEX_W-1:0];
    result_d.byte_offset = prod_x[fbpa_pkg::OFFSET_W-1:0];
    result_d.free_count  = free_x[fbpa_pkg::COUNT_W-1:0];
    result_d.capacity    = total_x[fbpa_pkg::COUNT_W-1:0];
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      ne_q     <= 1'b0;
      fresh_q  <= '0;
      free_q   <= CW'(fbpa_pkg::MIN_BUFFER);
      total_q  <= CW'(fbpa_pkg::MIN_BUFFER);
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      ne_q     <= ne_d;
      fresh_q  <= fresh_d;
      free_q   <= free_d;
      total_q  <= total_d;
      done_q   <= done_d;
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `FBPA_ASSERT(a_mark_in_capacity, fresh_q <= total_q, "high-water mark above capacity")
  `FBPA_ASSERT(a_capacity_bound, total_q <= CW'(POOL_BLOCKS), "capacity above pool size")
  `FBPA_ASSERT(a_link_after_read, (state_q == ST_LINK) |-> $past(ram_re), "link state without read")
  `FBPA_ASSERT(a_read_needs_list, ram_re |-> ne_q, "link read with an empty list")

endmodule

// ----- design/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator. An item (allocate, free or pool reset) is taken when
// start_i is high and busy_o is low; it waits in a two-entry command queue and its result
// appears on result_o for exactly one cycle with done_o high, registered in the back end.
// An allocation served from the free list passes through the link state of the execution
// stage, since the next list head comes from the registered read of the link memory;
// every other item completes from the idle state. The receiver cannot stall, so results
// are never held. A write of element_size holds cfg_ready_o low and busy_o high while the
// size is rounded up to the alignment. The link memory needs no clearing pass after reset.
module fixed_block_pool_allocator #(
  parameter int unsigned POOL_BLOCKS = 1024,
  parameter int unsigned ALIGNMENT   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  fbpa_pkg::in_item_t               item_i,
  output logic                             done_o,
  output fbpa_pkg::out_item_t              result_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic                             size_busy;
  logic                             cfg_we;
  logic                             size_load;
  logic [fbpa_pkg::COUNT_W-1:0]     bpb_q;
  logic                             static_q;
  logic [fbpa_pkg::EFF_W-1:0]       eff_size;
  fbpa_pkg::cfg_t                   cfg;
  logic                             cmd_valid;
  logic                             cmd_pop;
  fbpa_pkg::cmd_t                   cmd;

  // configuration write decode
  assign cfg_ready_o = !size_busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign size_load   = cfg_we && (cfg_index_i == fbpa_pkg::CFG_ELEMENT_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpb_q    <= fbpa_pkg::COUNT_W'(fbpa_pkg::MIN_BUFFER);
      static_q <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index_i == fbpa_pkg::CFG_BLOCKS_PER_BUFFER) begin
        bpb_q <= cfg_data_i[fbpa_pkg::COUNT_W-1:0];
      end
      if (cfg_index_i == fbpa_pkg::CFG_STATIC_MODE) begin
        static_q <= cfg_data_i[0];
      end
    end
  end

  // effective element size
  fbpa_size #(
    .ALIGNMENT(ALIGNMENT)
  ) u_size (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(size_load),
    .size_i(cfg_data_i),
    .busy_o(size_busy),
    .eff_o (eff_size)
  );

  always_comb begin
    cfg.eff_size          = eff_size;
    cfg.blocks_per_buffer = bpb_q;
    cfg.static_mode       = static_q;
  end

  // accept and queue
  fbpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .hold_i     (size_busy),
    .busy_o     (busy_o),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  // execute
  fbpa_back #(
    .POOL_BLOCKS(POOL_BLOCKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .cfg_i      (cfg),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
